FILE: sv/cpu_6502_bus_cycle_core_macros.svh
// assertion macros shared by the checker files
`ifndef CPU_6502_BUS_CYCLE_CORE_MACROS_SVH
`define CPU_6502_BUS_CYCLE_CORE_MACROS_SVH

// checked property, masked while reset is high
`define CPU65_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked property, also active during reset
`define CPU65_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/cpu65_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu65_pkg
// Types, codes, opcode decode and flag helpers of the 6502-style bus core.
// ----------------------------------------------------------------------------
package cpu65_pkg;

   // flag bit positions
   localparam int FL_C = 0;
   localparam int FL_Z = 1;
   localparam int FL_I = 2;
   localparam int FL_D = 3;
   localparam int FL_V = 6;
   localparam int FL_N = 7;

   // sequence steps
   localparam logic [3:0] ST_RESET   = 4'd0;
   localparam logic [3:0] ST_VEC_LO  = 4'd1;
   localparam logic [3:0] ST_VEC_HI  = 4'd2;
   localparam logic [3:0] ST_OPCODE  = 4'd3;
   localparam logic [3:0] ST_OPER1   = 4'd4;
   localparam logic [3:0] ST_ABS_HI  = 4'd5;
   localparam logic [3:0] ST_PTR_LO  = 4'd6;
   localparam logic [3:0] ST_PTR_HI  = 4'd7;
   localparam logic [3:0] ST_READ    = 4'd8;
   localparam logic [3:0] ST_RMW     = 4'd9;
   localparam logic [3:0] ST_WDONE   = 4'd10;
   localparam logic [3:0] ST_PUSH_HI = 4'd11;
   localparam logic [3:0] ST_PUSH_LO = 4'd12;
   localparam logic [3:0] ST_PUSH_P  = 4'd13;
   localparam logic [3:0] ST_PULL_A  = 4'd14;
   localparam logic [3:0] ST_PULL_B  = 4'd15;

   // addressing modes
   localparam logic [3:0] M_IMP = 4'd0;
   localparam logic [3:0] M_ACC = 4'd1;
   localparam logic [3:0] M_IMM = 4'd2;
   localparam logic [3:0] M_ZPG = 4'd3;
   localparam logic [3:0] M_ZPX = 4'd4;
   localparam logic [3:0] M_ZPY = 4'd5;
   localparam logic [3:0] M_REL = 4'd6;
   localparam logic [3:0] M_ABS = 4'd7;
   localparam logic [3:0] M_ABX = 4'd8;
   localparam logic [3:0] M_ABY = 4'd9;
   localparam logic [3:0] M_IND = 4'd10;
   localparam logic [3:0] M_IDX = 4'd11;
   localparam logic [3:0] M_IDY = 4'd12;

   // operations
   localparam logic [5:0] O_BAD = 6'd0;
   localparam logic [5:0] O_NOP = 6'd1;
   localparam logic [5:0] O_BRK = 6'd2;
   localparam logic [5:0] O_ORA = 6'd3;
   localparam logic [5:0] O_ASL = 6'd4;
   localparam logic [5:0] O_PHP = 6'd5;
   localparam logic [5:0] O_BPL = 6'd6;
   localparam logic [5:0] O_CLC = 6'd7;
   localparam logic [5:0] O_JSR = 6'd8;
   localparam logic [5:0] O_AND = 6'd9;
   localparam logic [5:0] O_BIT = 6'd10;
   localparam logic [5:0] O_ROL = 6'd11;
   localparam logic [5:0] O_PLP = 6'd12;
   localparam logic [5:0] O_BMI = 6'd13;
   localparam logic [5:0] O_SEC = 6'd14;
   localparam logic [5:0] O_RTI = 6'd15;
   localparam logic [5:0] O_EOR = 6'd16;
   localparam logic [5:0] O_LSR = 6'd17;
   localparam logic [5:0] O_PHA = 6'd18;
   localparam logic [5:0] O_JMP = 6'd19;
   localparam logic [5:0] O_BVC = 6'd20;
   localparam logic [5:0] O_CLI = 6'd21;
   localparam logic [5:0] O_RTS = 6'd22;
   localparam logic [5:0] O_ADC = 6'd23;
   localparam logic [5:0] O_ROR = 6'd24;
   localparam logic [5:0] O_PLA = 6'd25;
   localparam logic [5:0] O_BVS = 6'd26;
   localparam logic [5:0] O_SEI = 6'd27;
   localparam logic [5:0] O_STA = 6'd28;
   localparam logic [5:0] O_STY = 6'd29;
   localparam logic [5:0] O_STX = 6'd30;
   localparam logic [5:0] O_DEY = 6'd31;
   localparam logic [5:0] O_TXA = 6'd32;
   localparam logic [5:0] O_BCC = 6'd33;
   localparam logic [5:0] O_TYA = 6'd34;
   localparam logic [5:0] O_TXS = 6'd35;
   localparam logic [5:0] O_LDY = 6'd36;
   localparam logic [5:0] O_LDA = 6'd37;
   localparam logic [5:0] O_LDX = 6'd38;
   localparam logic [5:0] O_TAY = 6'd39;
   localparam logic [5:0] O_TAX = 6'd40;
   localparam logic [5:0] O_BCS = 6'd41;
   localparam logic [5:0] O_CLV = 6'd42;
   localparam logic [5:0] O_TSX = 6'd43;
   localparam logic [5:0] O_CPY = 6'd44;
   localparam logic [5:0] O_CMP = 6'd45;
   localparam logic [5:0] O_DEC = 6'd46;
   localparam logic [5:0] O_INY = 6'd47;
   localparam logic [5:0] O_DEX = 6'd48;
   localparam logic [5:0] O_BNE = 6'd49;
   localparam logic [5:0] O_CLD = 6'd50;
   localparam logic [5:0] O_CPX = 6'd51;
   localparam logic [5:0] O_SBC = 6'd52;
   localparam logic [5:0] O_INC = 6'd53;
   localparam logic [5:0] O_INX = 6'd54;
   localparam logic [5:0] O_BEQ = 6'd55;
   localparam logic [5:0] O_SED = 6'd56;

   // configuration register indexes
   localparam logic [7:0] CSR_RESET_VEC = 8'd0;
   localparam logic [7:0] CSR_IRQ_VEC   = 8'd1;
   localparam logic [7:0] CSR_NMI_VEC   = 8'd2;
   localparam logic [7:0] CSR_STACK_PG  = 8'd3;

   localparam logic [15:0] HALT_ADDR = 16'hffff;
   localparam logic [7:0]  P_KEEP    = 8'hcf;

   typedef struct packed {
      logic [5:0] op;
      logic [3:0] md;
   } cpu65_dec_type;

   typedef struct packed {
      logic [15:0] reset_vec;
      logic [15:0] irq_vec;
      logic [15:0] nmi_vec;
      logic [7:0]  stack_page;
   } cpu65_cfg_type;

   typedef struct packed {
      logic [15:0] pc;
      logic [7:0]  a;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  sp;
      logic [7:0]  p;
      logic [7:0]  opc;
      logic [15:0] ea;
      logic [15:0] pt;
      logic [3:0]  step;
      logic        nmi_lat;
      logic        nmi_pend;
      logic        irq_pend;
      logic        halt;
   } cpu65_state_type;

   typedef struct packed {
      logic [15:0] addr;
      logic        wr;
      logic [7:0]  data;
      logic        fetch;
      logic        halt;
   } cpu65_bus_type;

   typedef struct packed {
      logic [7:0] v;
      logic [7:0] p;
   } cpu65_alu_type;

   // z and n from a result byte
   function automatic logic [7:0] cpu65_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r = p;
      r[FL_Z] = (v == 8'h00);
      r[FL_N] = v[7];
      return r;
   endfunction

   // binary add with carry, also used for subtract with inverted operand
   function automatic cpu65_alu_type cpu65_add(input logic [7:0] a, input logic [7:0] m,
                                               input logic [7:0] p);
      logic [8:0]    s;
      cpu65_alu_type r;
      s = {1'b0, a} + {1'b0, m} + {8'h00, p[FL_C]};
      r.v = s[7:0];
      r.p = p;
      r.p[FL_V] = ~(a[7] ^ m[7]) & (a[7] ^ s[7]);
      r.p[FL_C] = s[8];
      r.p = cpu65_nz(r.p, s[7:0]);
      return r;
   endfunction

   // compare sets c, z, n
   function automatic logic [7:0] cpu65_cmp(input logic [7:0] r, input logic [7:0] m,
                                            input logic [7:0] p);
      logic [7:0] q;
      q = p;
      q[FL_C] = (r >= m);
      return cpu65_nz(q, r - m);
   endfunction

   // shifts, rotates, increment and decrement
   function automatic cpu65_alu_type cpu65_modify(input logic [5:0] op, input logic [7:0] v,
                                                  input logic [7:0] p);
      cpu65_alu_type r;
      r.p = p;
      case (op)
         O_ASL: begin
            r.p[FL_C] = v[7];
            r.v = {v[6:0], 1'b0};
         end
         O_LSR: begin
            r.p[FL_C] = v[0];
            r.v = {1'b0, v[7:1]};
         end
         O_ROL: begin
            r.p[FL_C] = v[7];
            r.v = {v[6:0], p[FL_C]};
         end
         O_ROR: begin
            r.p[FL_C] = v[0];
            r.v = {p[FL_C], v[7:1]};
         end
         O_INC: r.v = v + 8'd1;
         default: r.v = v - 8'd1;
      endcase
      r.p = cpu65_nz(r.p, r.v);
      return r;
   endfunction

   // branch condition
   function automatic logic cpu65_taken(input logic [5:0] op, input logic [7:0] p);
      logic t;
      case (op)
         O_BPL: t = ~p[FL_N];
         O_BMI: t = p[FL_N];
         O_BVC: t = ~p[FL_V];
         O_BVS: t = p[FL_V];
         O_BCC: t = ~p[FL_C];
         O_BCS: t = p[FL_C];
         O_BNE: t = ~p[FL_Z];
         default: t = p[FL_Z];
      endcase
      return t;
   endfunction

   // opcode decode table
   function automatic cpu65_dec_type cpu65_decode(input logic [7:0] opc);
      cpu65_dec_type d;
      case (opc)
         8'h00: d = '{O_BRK, M_IMP};  8'h01: d = '{O_ORA, M_IDX};
         8'h04: d = '{O_NOP, M_ZPG};  8'h05: d = '{O_ORA, M_ZPG};  8'h06: d = '{O_ASL, M_ZPG};
         8'h08: d = '{O_PHP, M_IMP};  8'h09: d = '{O_ORA, M_IMM};  8'h0a: d = '{O_ASL, M_ACC};
         8'h0c: d = '{O_NOP, M_ABS};  8'h0d: d = '{O_ORA, M_ABS};  8'h0e: d = '{O_ASL, M_ABS};
         8'h10: d = '{O_BPL, M_REL};  8'h11: d = '{O_ORA, M_IDY};
         8'h14: d = '{O_NOP, M_ZPX};  8'h15: d = '{O_ORA, M_ZPX};  8'h16: d = '{O_ASL, M_ZPX};
         8'h18: d = '{O_CLC, M_IMP};  8'h19: d = '{O_ORA, M_ABY};  8'h1a: d = '{O_NOP, M_IMP};
         8'h1c: d = '{O_NOP, M_ABX};  8'h1d: d = '{O_ORA, M_ABX};  8'h1e: d = '{O_ASL, M_ABX};
         8'h20: d = '{O_JSR, M_ABS};  8'h21: d = '{O_AND, M_IDX};
         8'h24: d = '{O_BIT, M_ZPG};  8'h25: d = '{O_AND, M_ZPG};  8'h26: d = '{O_ROL, M_ZPG};
         8'h28: d = '{O_PLP, M_IMP};  8'h29: d = '{O_AND, M_IMM};  8'h2a: d = '{O_ROL, M_ACC};
         8'h2c: d = '{O_BIT, M_ABS};  8'h2d: d = '{O_AND, M_ABS};  8'h2e: d = '{O_ROL, M_ABS};
         8'h30: d = '{O_BMI, M_REL};  8'h31: d = '{O_AND, M_IDY};
         8'h34: d = '{O_NOP, M_ZPX};  8'h35: d = '{O_AND, M_ZPX};  8'h36: d = '{O_ROL, M_ZPX};
         8'h38: d = '{O_SEC, M_IMP};  8'h39: d = '{O_AND, M_ABY};  8'h3a: d = '{O_NOP, M_IMP};
         8'h3c: d = '{O_NOP, M_ABX};  8'h3d: d = '{O_AND, M_ABX};  8'h3e: d = '{O_ROL, M_ABX};
         8'h40: d = '{O_RTI, M_IMP};  8'h41: d = '{O_EOR, M_IDX};
         8'h44: d = '{O_NOP, M_ZPG};  8'h45: d = '{O_EOR, M_ZPG};  8'h46: d = '{O_LSR, M_ZPG};
         8'h48: d = '{O_PHA, M_IMP};  8'h49: d = '{O_EOR, M_IMM};  8'h4a: d = '{O_LSR, M_ACC};
         8'h4c: d = '{O_JMP, M_ABS};  8'h4d: d = '{O_EOR, M_ABS};  8'h4e: d = '{O_LSR, M_ABS};
         8'h50: d = '{O_BVC, M_REL};  8'h51: d = '{O_EOR, M_IDY};
         8'h54: d = '{O_NOP, M_ZPX};  8'h55: d = '{O_EOR, M_ZPX};  8'h56: d = '{O_LSR, M_ZPX};
         8'h58: d = '{O_CLI, M_IMP};  8'h59: d = '{O_EOR, M_ABY};  8'h5a: d = '{O_NOP, M_IMP};
         8'h5c: d = '{O_NOP, M_ABX};  8'h5d: d = '{O_EOR, M_ABX};  8'h5e: d = '{O_LSR, M_ABX};
         8'h60: d = '{O_RTS, M_IMP};  8'h61: d = '{O_ADC, M_IDX};
         8'h64: d = '{O_NOP, M_ZPG};  8'h65: d = '{O_ADC, M_ZPG};  8'h66: d = '{O_ROR, M_ZPG};
         8'h68: d = '{O_PLA, M_IMP};  8'h69: d = '{O_ADC, M_IMM};  8'h6a: d = '{O_ROR, M_ACC};
         8'h6c: d = '{O_JMP, M_IND};  8'h6d: d = '{O_ADC, M_ABS};  8'h6e: d = '{O_ROR, M_ABS};
         8'h70: d = '{O_BVS, M_REL};  8'h71: d = '{O_ADC, M_IDY};
         8'h74: d = '{O_NOP, M_ZPX};  8'h75: d = '{O_ADC, M_ZPX};  8'h76: d = '{O_ROR, M_ZPX};
         8'h78: d = '{O_SEI, M_IMP};  8'h79: d = '{O_ADC, M_ABY};  8'h7a: d = '{O_NOP, M_IMP};
         8'h7c: d = '{O_NOP, M_ABX};  8'h7d: d = '{O_ADC, M_ABX};  8'h7e: d = '{O_ROR, M_ABX};
         8'h80: d = '{O_NOP, M_IMM};  8'h81: d = '{O_STA, M_IDX};  8'h82: d = '{O_NOP, M_IMM};
         8'h84: d = '{O_STY, M_ZPG};  8'h85: d = '{O_STA, M_ZPG};  8'h86: d = '{O_STX, M_ZPG};
         8'h88: d = '{O_DEY, M_IMP};  8'h89: d = '{O_NOP, M_IMM};  8'h8a: d = '{O_TXA, M_IMP};
         8'h8c: d = '{O_STY, M_ABS};  8'h8d: d = '{O_STA, M_ABS};  8'h8e: d = '{O_STX, M_ABS};
         8'h90: d = '{O_BCC, M_REL};  8'h91: d = '{O_STA, M_IDY};
         8'h94: d = '{O_STY, M_ZPX};  8'h95: d = '{O_STA, M_ZPX};  8'h96: d = '{O_STX, M_ZPY};
         8'h98: d = '{O_TYA, M_IMP};  8'h99: d = '{O_STA, M_ABY};  8'h9a: d = '{O_TXS, M_IMP};
         8'h9d: d = '{O_STA, M_ABX};
         8'ha0: d = '{O_LDY, M_IMM};  8'ha1: d = '{O_LDA, M_IDX};  8'ha2: d = '{O_LDX, M_IMM};
         8'ha4: d = '{O_LDY, M_ZPG};  8'ha5: d = '{O_LDA, M_ZPG};  8'ha6: d = '{O_LDX, M_ZPG};
         8'ha8: d = '{O_TAY, M_IMP};  8'ha9: d = '{O_LDA, M_IMM};  8'haa: d = '{O_TAX, M_IMP};
         8'hac: d = '{O_LDY, M_ABS};  8'had: d = '{O_LDA, M_ABS};  8'hae: d = '{O_LDX, M_ABS};
         8'hb0: d = '{O_BCS, M_REL};  8'hb1: d = '{O_LDA, M_IDY};
         8'hb4: d = '{O_LDY, M_ZPX};  8'hb5: d = '{O_LDA, M_ZPX};  8'hb6: d = '{O_LDX, M_ZPY};
         8'hb8: d = '{O_CLV, M_IMP};  8'hb9: d = '{O_LDA, M_ABY};  8'hba: d = '{O_TSX, M_IMP};
         8'hbc: d = '{O_LDY, M_ABX};  8'hbd: d = '{O_LDA, M_ABX};  8'hbe: d = '{O_LDX, M_ABY};
         8'hc0: d = '{O_CPY, M_IMM};  8'hc1: d = '{O_CMP, M_IDX};  8'hc2: d = '{O_NOP, M_IMM};
         8'hc4: d = '{O_CPY, M_ZPG};  8'hc5: d = '{O_CMP, M_ZPG};  8'hc6: d = '{O_DEC, M_ZPG};
         8'hc8: d = '{O_INY, M_IMP};  8'hc9: d = '{O_CMP, M_IMM};  8'hca: d = '{O_DEX, M_IMP};
         8'hcc: d = '{O_CPY, M_ABS};  8'hcd: d = '{O_CMP, M_ABS};  8'hce: d = '{O_DEC, M_ABS};
         8'hd0: d = '{O_BNE, M_REL};  8'hd1: d = '{O_CMP, M_IDY};
         8'hd4: d = '{O_NOP, M_ZPX};  8'hd5: d = '{O_CMP, M_ZPX};  8'hd6: d = '{O_DEC, M_ZPX};
         8'hd8: d = '{O_CLD, M_IMP};  8'hd9: d = '{O_CMP, M_ABY};  8'hda: d = '{O_NOP, M_IMP};
         8'hdc: d = '{O_NOP, M_ABX};  8'hdd: d = '{O_CMP, M_ABX};  8'hde: d = '{O_DEC, M_ABX};
         8'he0: d = '{O_CPX, M_IMM};  8'he1: d = '{O_SBC, M_IDX};  8'he2: d = '{O_NOP, M_IMM};
         8'he4: d = '{O_CPX, M_ZPG};  8'he5: d = '{O_SBC, M_ZPG};  8'he6: d = '{O_INC, M_ZPG};
         8'he8: d = '{O_INX, M_IMP};  8'he9: d = '{O_SBC, M_IMM};  8'hea: d = '{O_NOP, M_IMP};
         8'hec: d = '{O_CPX, M_ABS};  8'hed: d = '{O_SBC, M_ABS};  8'hee: d = '{O_INC, M_ABS};
         8'hf0: d = '{O_BEQ, M_REL};  8'hf1: d = '{O_SBC, M_IDY};
         8'hf4: d = '{O_NOP, M_ZPX};  8'hf5: d = '{O_SBC, M_ZPX};  8'hf6: d = '{O_INC, M_ZPX};
         8'hf8: d = '{O_SED, M_IMP};  8'hf9: d = '{O_SBC, M_ABY};  8'hfa: d = '{O_NOP, M_IMP};
         8'hfc: d = '{O_NOP, M_ABX};  8'hfd: d = '{O_SBC, M_ABX};  8'hfe: d = '{O_INC, M_ABX};
         default: d = '{O_BAD, M_IMP};
      endcase
      return d;
   endfunction

endpackage

FILE: sv/cpu65_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu65_seq
// Next-state and bus request logic: one bus response in, one bus access out.
// ----------------------------------------------------------------------------
module cpu65_seq (
   input  cpu65_pkg::cpu65_state_type cur,
   input  cpu65_pkg::cpu65_cfg_type   cfg,
   input  logic [7:0]                 read_data,
   input  logic                       irq_level,
   input  logic                       nmi_fell,
   output cpu65_pkg::cpu65_state_type nxt,
   output cpu65_pkg::cpu65_bus_type   bus
);
   import cpu65_pkg::*;

   cpu65_state_type s;
   cpu65_bus_type   r;
   cpu65_dec_type   dec_c;
   cpu65_dec_type   dec_n;
   cpu65_alu_type   alu;
   logic [5:0]      op;
   logic [3:0]      md;
   logic [15:0]     base;
   logic [15:0]     int_vec;
   logic            do_impl;
   logic            do_opnd;
   logic            do_bnd;
   logic            do_int;

   always_comb begin
      s       = cur;
      r       = '0;
      alu     = '0;
      base    = '0;
      int_vec = '0;
      do_impl = 1'b0;
      do_opnd = 1'b0;
      do_bnd  = 1'b0;
      do_int  = 1'b0;
      dec_c   = cpu65_decode(cur.opc);
      dec_n   = cpu65_decode(read_data);
      op      = dec_c.op;
      md      = dec_c.md;

      if (nmi_fell) begin
         s.nmi_lat = 1'b1;
      end

      // main step
      if (cur.halt) begin
         r.addr = HALT_ADDR;
      end else begin
         case (cur.step)
            ST_RESET: begin
               s.pt   = cfg.reset_vec;
               r.addr = cfg.reset_vec;
               s.step = ST_VEC_LO;
            end
            ST_VEC_LO: begin
               s.ea   = {8'h00, read_data};
               r.addr = cur.pt + 16'd1;
               s.step = ST_VEC_HI;
            end
            ST_VEC_HI: begin
               s.pc      = {read_data, cur.ea[7:0]};
               s.p[FL_I] = 1'b1;
               do_bnd    = 1'b1;
            end
            ST_OPCODE: begin
               s.opc = read_data;
               op    = dec_n.op;
               md    = dec_n.md;
               if (dec_n.op == O_BAD) begin
                  s.halt = 1'b1;
                  r.addr = HALT_ADDR;
                  s.step = ST_OPCODE;
               end else if (dec_n.md == M_IMP || dec_n.md == M_ACC) begin
                  do_impl = 1'b1;
               end else if (dec_n.md == M_IMM) begin
                  s.ea    = cur.pc;
                  s.pc    = cur.pc + 16'd1;
                  do_opnd = 1'b1;
               end else begin
                  r.addr = cur.pc;
                  s.pc   = cur.pc + 16'd1;
                  s.step = ST_OPER1;
               end
            end
            ST_OPER1: begin
               case (md)
                  M_ZPG: begin
                     s.ea    = {8'h00, read_data};
                     do_opnd = 1'b1;
                  end
                  M_ZPX: begin
                     s.ea    = {8'h00, read_data + cur.x};
                     do_opnd = 1'b1;
                  end
                  M_ZPY: begin
                     s.ea    = {8'h00, read_data + cur.y};
                     do_opnd = 1'b1;
                  end
                  M_REL: begin
                     if (cpu65_taken(op, cur.p)) begin
                        s.pc = cur.pc + {{8{read_data[7]}}, read_data};
                     end
                     do_bnd = 1'b1;
                  end
                  M_IDX: begin
                     s.pt   = {8'h00, read_data + cur.x};
                     r.addr = s.pt;
                     s.step = ST_PTR_LO;
                  end
                  M_IDY: begin
                     s.pt   = {8'h00, read_data};
                     r.addr = s.pt;
                     s.step = ST_PTR_LO;
                  end
                  default: begin
                     s.ea   = {8'h00, read_data};
                     r.addr = cur.pc;
                     s.pc   = cur.pc + 16'd1;
                     s.step = ST_ABS_HI;
                  end
               endcase
            end
            ST_ABS_HI: begin
               base = {read_data, cur.ea[7:0]};
               if (md == M_IND) begin
                  s.pt   = base;
                  r.addr = base;
                  s.step = ST_PTR_LO;
               end else begin
                  if (md == M_ABX) begin
                     base = base + {8'h00, cur.x};
                  end else if (md == M_ABY) begin
                     base = base + {8'h00, cur.y};
                  end
                  s.ea    = base;
                  do_opnd = 1'b1;
               end
            end
            ST_PTR_LO: begin
               s.ea = {8'h00, read_data};
               // indirect jump wraps inside the pointer page, zero page pointers wrap at 8 bits
               if (md == M_IND) begin
                  r.addr = {cur.pt[15:8], cur.pt[7:0] + 8'd1};
               end else begin
                  r.addr = {8'h00, cur.pt[7:0] + 8'd1};
               end
               s.step = ST_PTR_HI;
            end
            ST_PTR_HI: begin
               base = {read_data, cur.ea[7:0]};
               if (md == M_IND) begin
                  s.pc   = base;
                  do_bnd = 1'b1;
               end else begin
                  if (md == M_IDY) begin
                     base = base + {8'h00, cur.y};
                  end
                  s.ea    = base;
                  do_opnd = 1'b1;
               end
            end
            ST_READ: begin
               case (op)
                  O_ORA: begin
                     s.a = cur.a | read_data;
                     s.p = cpu65_nz(cur.p, s.a);
                  end
                  O_AND: begin
                     s.a = cur.a & read_data;
                     s.p = cpu65_nz(cur.p, s.a);
                  end
                  O_EOR: begin
                     s.a = cur.a ^ read_data;
                     s.p = cpu65_nz(cur.p, s.a);
                  end
                  O_ADC: begin
                     alu = cpu65_add(cur.a, read_data, cur.p);
                     s.a = alu.v;
                     s.p = alu.p;
                  end
                  O_SBC: begin
                     alu = cpu65_add(cur.a, ~read_data, cur.p);
                     s.a = alu.v;
                     s.p = alu.p;
                  end
                  O_CMP: s.p = cpu65_cmp(cur.a, read_data, cur.p);
                  O_CPX: s.p = cpu65_cmp(cur.x, read_data, cur.p);
                  O_CPY: s.p = cpu65_cmp(cur.y, read_data, cur.p);
                  O_BIT: begin
                     s.p[FL_Z] = ((read_data & cur.a) == 8'h00);
                     s.p[FL_V] = read_data[6];
                     s.p[FL_N] = read_data[7];
                  end
                  O_LDX: begin
                     s.x = read_data;
                     s.p = cpu65_nz(cur.p, read_data);
                  end
                  O_LDY: begin
                     s.y = read_data;
                     s.p = cpu65_nz(cur.p, read_data);
                  end
                  default: begin
                     s.a = read_data;
                     s.p = cpu65_nz(cur.p, read_data);
                  end
               endcase
               do_bnd = 1'b1;
            end
            ST_RMW: begin
               alu    = cpu65_modify(op, read_data, cur.p);
               s.p    = alu.p;
               r.addr = cur.ea;
               r.wr   = 1'b1;
               r.data = alu.v;
               s.step = ST_WDONE;
            end
            ST_WDONE: do_bnd = 1'b1;
            ST_PUSH_HI: begin
               r.addr = {cfg.stack_page, cur.sp};
               r.wr   = 1'b1;
               r.data = cur.pc[7:0];
               s.sp   = cur.sp - 8'd1;
               s.step = ST_PUSH_LO;
            end
            ST_PUSH_LO: begin
               if (op == O_JSR) begin
                  s.pc   = cur.ea;
                  do_bnd = 1'b1;
               end else begin
                  // break bit only for a software break
                  r.addr = {cfg.stack_page, cur.sp};
                  r.wr   = 1'b1;
                  r.data = cur.p | ((cur.nmi_pend || cur.irq_pend) ? 8'h20 : 8'h30);
                  s.sp   = cur.sp - 8'd1;
                  s.step = ST_PUSH_P;
               end
            end
            ST_PUSH_P: begin
               s.p[FL_I] = 1'b1;
               r.addr    = cur.pt;
               s.step    = ST_VEC_LO;
            end
            ST_PULL_A: begin
               if (op == O_PLA) begin
                  s.a    = read_data;
                  s.p    = cpu65_nz(cur.p, read_data);
                  do_bnd = 1'b1;
               end else if (op == O_PLP) begin
                  s.p    = read_data & P_KEEP;
                  do_bnd = 1'b1;
               end else begin
                  if (op == O_RTS) begin
                     s.ea = {8'h00, read_data};
                     s.pt = 16'd1;
                  end else begin
                     s.p  = read_data & P_KEEP;
                     s.pt = 16'd0;
                  end
                  s.sp   = cur.sp + 8'd1;
                  r.addr = {cfg.stack_page, s.sp};
                  s.step = ST_PULL_B;
               end
            end
            default: begin
               // pull return address low then high
               if (cur.pt == 16'd0) begin
                  s.ea   = {8'h00, read_data};
                  s.pt   = 16'd1;
                  s.sp   = cur.sp + 8'd1;
                  r.addr = {cfg.stack_page, s.sp};
                  s.step = ST_PULL_B;
               end else begin
                  base = {read_data, cur.ea[7:0]};
                  if (op == O_RTS) begin
                     base = base + 16'd1;
                  end
                  s.pc   = base;
                  do_bnd = 1'b1;
               end
            end
         endcase
      end

      // single byte instructions
      if (do_impl) begin
         do_bnd = 1'b1;
         case (op)
            O_CLC: s.p[FL_C] = 1'b0;
            O_SEC: s.p[FL_C] = 1'b1;
            O_CLI: s.p[FL_I] = 1'b0;
            O_SEI: s.p[FL_I] = 1'b1;
            O_CLV: s.p[FL_V] = 1'b0;
            O_CLD: s.p[FL_D] = 1'b0;
            O_SED: s.p[FL_D] = 1'b1;
            O_TAX: begin
               s.x = s.a;
               s.p = cpu65_nz(s.p, s.a);
            end
            O_TAY: begin
               s.y = s.a;
               s.p = cpu65_nz(s.p, s.a);
            end
            O_TXA: begin
               s.a = s.x;
               s.p = cpu65_nz(s.p, s.x);
            end
            O_TYA: begin
               s.a = s.y;
               s.p = cpu65_nz(s.p, s.y);
            end
            O_TSX: begin
               s.x = s.sp;
               s.p = cpu65_nz(s.p, s.sp);
            end
            O_TXS: s.sp = s.x;
            O_INX: begin
               s.x = s.x + 8'd1;
               s.p = cpu65_nz(s.p, s.x);
            end
            O_INY: begin
               s.y = s.y + 8'd1;
               s.p = cpu65_nz(s.p, s.y);
            end
            O_DEX: begin
               s.x = s.x - 8'd1;
               s.p = cpu65_nz(s.p, s.x);
            end
            O_DEY: begin
               s.y = s.y - 8'd1;
               s.p = cpu65_nz(s.p, s.y);
            end
            O_ASL, O_LSR, O_ROL, O_ROR: begin
               alu = cpu65_modify(op, s.a, s.p);
               s.a = alu.v;
               s.p = alu.p;
            end
            O_PHA, O_PHP: begin
               r.addr = {cfg.stack_page, s.sp};
               r.wr   = 1'b1;
               r.data = (op == O_PHA) ? s.a : (s.p | 8'h30);
               s.sp   = s.sp - 8'd1;
               s.step = ST_WDONE;
               do_bnd = 1'b0;
            end
            O_PLA, O_PLP, O_RTS, O_RTI: begin
               s.sp   = s.sp + 8'd1;
               r.addr = {cfg.stack_page, s.sp};
               s.step = ST_PULL_A;
               do_bnd = 1'b0;
            end
            O_BRK: begin
               s.pc    = s.pc + 16'd1;
               int_vec = cfg.irq_vec;
               do_int  = 1'b1;
               do_bnd  = 1'b0;
            end
            default: ;
         endcase
      end

      // instructions with an effective address
      if (do_opnd) begin
         case (op)
            O_NOP: do_bnd = 1'b1;
            O_STA, O_STX, O_STY: begin
               r.addr = s.ea;
               r.wr   = 1'b1;
               r.data = (op == O_STA) ? s.a : ((op == O_STX) ? s.x : s.y);
               s.step = ST_WDONE;
            end
            O_ASL, O_LSR, O_ROL, O_ROR, O_INC, O_DEC: begin
               r.addr = s.ea;
               s.step = ST_RMW;
            end
            O_JMP: begin
               s.pc   = s.ea;
               do_bnd = 1'b1;
            end
            O_JSR: begin
               s.pc   = s.pc - 16'd1;
               r.addr = {cfg.stack_page, s.sp};
               r.wr   = 1'b1;
               r.data = s.pc[15:8];
               s.sp   = s.sp - 8'd1;
               s.step = ST_PUSH_HI;
            end
            default: begin
               r.addr = s.ea;
               s.step = ST_READ;
            end
         endcase
      end

      // instruction boundary: interrupt poll or opcode fetch
      if (do_bnd) begin
         s.nmi_pend = s.nmi_lat;
         s.irq_pend = irq_level & ~s.p[FL_I];
         if (s.nmi_pend) begin
            s.nmi_lat = 1'b0;
            int_vec   = cfg.nmi_vec;
            do_int    = 1'b1;
         end else if (s.irq_pend) begin
            int_vec = cfg.irq_vec;
            do_int  = 1'b1;
         end else begin
            r.addr  = s.pc;
            r.fetch = 1'b1;
            s.pc    = s.pc + 16'd1;
            s.step  = ST_OPCODE;
         end
      end

      // vector sequence start: push pc high
      if (do_int) begin
         s.opc  = 8'h00;
         s.pt   = int_vec;
         r.addr = {cfg.stack_page, s.sp};
         r.wr   = 1'b1;
         r.data = s.pc[15:8];
         s.sp   = s.sp - 8'd1;
         s.step = ST_PUSH_HI;
      end

      r.halt = s.halt;
      nxt    = s;
      bus    = r;
   end

endmodule

FILE: sv/cpu_6502_bus_cycle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_6502_bus_cycle_core
// 6502-style core, binary arithmetic only: one bus response in, one bus
// access out per item.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | read_data, irq_level, nmi_fell
//   rsp     | out       | rsp_valid/rsp_stall | bus_address, bus_write, write_data,
//           |           |                     | opcode_fetch, halted
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// The architectural registers feed the step logic and the next bus access
// lands in the result register on the accepting edge. One item per cycle
// sustained while no result is held; the result register frees on the cycle it
// is taken, so the next item is accepted in that same cycle.
// Reset sets the core to the reset vector fetch step; the first item's
// read_data is ignored. req_stall is high only while a result is held.
// ----------------------------------------------------------------------------
module cpu_6502_bus_cycle_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_read_data,
   input  logic        req_irq_level,
   input  logic        req_nmi_fell,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_bus_address,
   output logic        rsp_bus_write,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_opcode_fetch,
   output logic        rsp_halted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import cpu65_pkg::*;

   cpu65_state_type state_ff;
   cpu65_state_type state_in;
   cpu65_cfg_type   cfg_ff;
   cpu65_bus_type   bus_in;
   cpu65_bus_type   bus_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            accept;

   // handshake
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   assign csr_ready    = 1'b1;

   // step logic
   cpu65_seq u_seq (
      .cur       (state_ff),
      .cfg       (cfg_ff),
      .read_data (req_read_data),
      .irq_level (req_irq_level),
      .nmi_fell  (req_nmi_fell),
      .nxt       (state_in),
      .bus       (bus_in)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{reset_vec: 16'hfffc, irq_vec: 16'hfffe, nmi_vec: 16'hfffa,
                     stack_page: 8'h01};
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RESET_VEC: cfg_ff.reset_vec  <= csr_wdata;
            CSR_IRQ_VEC:   cfg_ff.irq_vec    <= csr_wdata;
            CSR_NMI_VEC:   cfg_ff.nmi_vec    <= csr_wdata;
            CSR_STACK_PG:  cfg_ff.stack_page <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{sp: 8'hfd, p: 8'h04, step: ST_RESET, default: '0};
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bus_ff <= bus_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bus_address  = bus_ff.addr;
   assign rsp_bus_write    = bus_ff.wr;
   assign rsp_write_data   = bus_ff.data;
   assign rsp_opcode_fetch = bus_ff.fetch;
   assign rsp_halted       = bus_ff.halt;

endmodule

FILE: sv/cpu65_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu65_checker
// Port-level checks of the bus core, bound to the top level.
// ----------------------------------------------------------------------------
`include "cpu_6502_bus_cycle_core_macros.svh"

module cpu65_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_bus_address,
   input logic        rsp_bus_write,
   input logic [7:0]  rsp_write_data,
   input logic        rsp_opcode_fetch,
   input logic        rsp_halted
);

   // no result right after reset
   `CPU65_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // halted core only reads the top address
   `CPU65_ASSERT(a_halt_bus, rsp_valid && rsp_halted |-> rsp_bus_address == 16'hffff && !rsp_bus_write && !rsp_opcode_fetch, "halted access wrong")

   // reads carry zero data
   `CPU65_ASSERT(a_read_data, rsp_valid && !rsp_bus_write |-> rsp_write_data == 8'h00, "read with data")

   // input side stalls only behind a held result
   `CPU65_ASSERT(a_stall_src, req_stall |-> rsp_valid && rsp_stall, "stall without held item")

   // held result stays put
   `CPU65_ASSERT(a_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bus_address), "held item changed")

endmodule

bind cpu_6502_bus_cycle_core cpu65_checker u_cpu65_checker (.*);

FILE: verif/tb_cpu_6502_bus_cycle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu_6502_bus_cycle_core
// Plays the memory side of the core: every item answers the previous bus
// access, and every bus access is checked against a cycle-step model of the
// processor kept here. A short directed program runs first, then three
// random phases with different idle patterns, and the run ends by halting
// the core on an undefined opcode.
// ----------------------------------------------------------------------------
module tb_cpu_6502_bus_cycle_core;
   import cpu65_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_read_data = 8'h00;
   logic        req_irq_level = 1'b0;
   logic        req_nmi_fell = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_bus_address;
   logic        rsp_bus_write;
   logic [7:0]  rsp_write_data;
   logic        rsp_opcode_fetch;
   logic        rsp_halted;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = 8'h00;
   logic [15:0] csr_wdata = 16'h0000;

   cpu_6502_bus_cycle_core dut (.*);

   always #2 clock = ~clock;

   // model state
   logic [15:0] cfg_reset_vec, cfg_irq_vec, cfg_nmi_vec;
   logic [7:0]  cfg_stack_pg;
   logic [15:0] m_pc, m_ea, m_pt;
   logic [7:0]  m_a, m_x, m_y, m_sp, m_p, m_opc;
   logic [3:0]  m_step;
   logic        m_nmi_lat, m_nmi_pend, m_irq_pend, m_halt;
   cpu65_bus_type m_bus;
   logic [9:0]  decode_rom [256];

   cpu65_bus_type bus_expected [$];
   int  errors = 0;
   int  cycles = 0;
   int  send_idle_pct = 7;
   int  recv_idle_pct = 83;
   bit  hold_off = 1'b0;

   // opcode table: operation in the upper bits, addressing mode in the lower
   task automatic def(input logic [7:0] c, input logic [5:0] op, input logic [3:0] md);
      decode_rom[c] = {op, md};
   endtask

   initial begin
      for (int i = 0; i < 256; i++) decode_rom[i] = {O_BAD, M_IMP};
      def(8'h00, O_BRK, M_IMP); def(8'h01, O_ORA, M_IDX); def(8'h04, O_NOP, M_ZPG);
      def(8'h05, O_ORA, M_ZPG); def(8'h06, O_ASL, M_ZPG); def(8'h08, O_PHP, M_IMP);
      def(8'h09, O_ORA, M_IMM); def(8'h0a, O_ASL, M_ACC); def(8'h0c, O_NOP, M_ABS);
      def(8'h0d, O_ORA, M_ABS); def(8'h0e, O_ASL, M_ABS); def(8'h10, O_BPL, M_REL);
      def(8'h11, O_ORA, M_IDY); def(8'h14, O_NOP, M_ZPX); def(8'h15, O_ORA, M_ZPX);
      def(8'h16, O_ASL, M_ZPX); def(8'h18, O_CLC, M_IMP); def(8'h19, O_ORA, M_ABY);
      def(8'h1a, O_NOP, M_IMP); def(8'h1c, O_NOP, M_ABX); def(8'h1d, O_ORA, M_ABX);
      def(8'h1e, O_ASL, M_ABX); def(8'h20, O_JSR, M_ABS); def(8'h21, O_AND, M_IDX);
      def(8'h24, O_BIT, M_ZPG); def(8'h25, O_AND, M_ZPG); def(8'h26, O_ROL, M_ZPG);
      def(8'h28, O_PLP, M_IMP); def(8'h29, O_AND, M_IMM); def(8'h2a, O_ROL, M_ACC);
      def(8'h2c, O_BIT, M_ABS); def(8'h2d, O_AND, M_ABS); def(8'h2e, O_ROL, M_ABS);
      def(8'h30, O_BMI, M_REL); def(8'h31, O_AND, M_IDY); def(8'h34, O_NOP, M_ZPX);
      def(8'h35, O_AND, M_ZPX); def(8'h36, O_ROL, M_ZPX); def(8'h38, O_SEC, M_IMP);
      def(8'h39, O_AND, M_ABY); def(8'h3a, O_NOP, M_IMP); def(8'h3c, O_NOP, M_ABX);
      def(8'h3d, O_AND, M_ABX); def(8'h3e, O_ROL, M_ABX); def(8'h40, O_RTI, M_IMP);
      def(8'h41, O_EOR, M_IDX); def(8'h44, O_NOP, M_ZPG); def(8'h45, O_EOR, M_ZPG);
      def(8'h46, O_LSR, M_ZPG); def(8'h48, O_PHA, M_IMP); def(8'h49, O_EOR, M_IMM);
      def(8'h4a, O_LSR, M_ACC); def(8'h4c, O_JMP, M_ABS); def(8'h4d, O_EOR, M_ABS);
      def(8'h4e, O_LSR, M_ABS); def(8'h50, O_BVC, M_REL); def(8'h51, O_EOR, M_IDY);
      def(8'h54, O_NOP, M_ZPX); def(8'h55, O_EOR, M_ZPX); def(8'h56, O_LSR, M_ZPX);
      def(8'h58, O_CLI, M_IMP); def(8'h59, O_EOR, M_ABY); def(8'h5a, O_NOP, M_IMP);
      def(8'h5c, O_NOP, M_ABX); def(8'h5d, O_EOR, M_ABX); def(8'h5e, O_LSR, M_ABX);
      def(8'h60, O_RTS, M_IMP); def(8'h61, O_ADC, M_IDX); def(8'h64, O_NOP, M_ZPG);
      def(8'h65, O_ADC, M_ZPG); def(8'h66, O_ROR, M_ZPG); def(8'h68, O_PLA, M_IMP);
      def(8'h69, O_ADC, M_IMM); def(8'h6a, O_ROR, M_ACC); def(8'h6c, O_JMP, M_IND);
      def(8'h6d, O_ADC, M_ABS); def(8'h6e, O_ROR, M_ABS); def(8'h70, O_BVS, M_REL);
      def(8'h71, O_ADC, M_IDY); def(8'h74, O_NOP, M_ZPX); def(8'h75, O_ADC, M_ZPX);
      def(8'h76, O_ROR, M_ZPX); def(8'h78, O_SEI, M_IMP); def(8'h79, O_ADC, M_ABY);
      def(8'h7a, O_NOP, M_IMP); def(8'h7c, O_NOP, M_ABX); def(8'h7d, O_ADC, M_ABX);
      def(8'h7e, O_ROR, M_ABX); def(8'h80, O_NOP, M_IMM); def(8'h81, O_STA, M_IDX);
      def(8'h82, O_NOP, M_IMM); def(8'h84, O_STY, M_ZPG); def(8'h85, O_STA, M_ZPG);
      def(8'h86, O_STX, M_ZPG); def(8'h88, O_DEY, M_IMP); def(8'h89, O_NOP, M_IMM);
      def(8'h8a, O_TXA, M_IMP); def(8'h8c, O_STY, M_ABS); def(8'h8d, O_STA, M_ABS);
      def(8'h8e, O_STX, M_ABS); def(8'h90, O_BCC, M_REL); def(8'h91, O_STA, M_IDY);
      def(8'h94, O_STY, M_ZPX); def(8'h95, O_STA, M_ZPX); def(8'h96, O_STX, M_ZPY);
      def(8'h98, O_TYA, M_IMP); def(8'h99, O_STA, M_ABY); def(8'h9a, O_TXS, M_IMP);
      def(8'h9d, O_STA, M_ABX); def(8'ha0, O_LDY, M_IMM); def(8'ha1, O_LDA, M_IDX);
      def(8'ha2, O_LDX, M_IMM); def(8'ha4, O_LDY, M_ZPG); def(8'ha5, O_LDA, M_ZPG);
      def(8'ha6, O_LDX, M_ZPG); def(8'ha8, O_TAY, M_IMP); def(8'ha9, O_LDA, M_IMM);
      def(8'haa, O_TAX, M_IMP); def(8'hac, O_LDY, M_ABS); def(8'had, O_LDA, M_ABS);
      def(8'hae, O_LDX, M_ABS); def(8'hb0, O_BCS, M_REL); def(8'hb1, O_LDA, M_IDY);
      def(8'hb4, O_LDY, M_ZPX); def(8'hb5, O_LDA, M_ZPX); def(8'hb6, O_LDX, M_ZPY);
      def(8'hb8, O_CLV, M_IMP); def(8'hb9, O_LDA, M_ABY); def(8'hba, O_TSX, M_IMP);
      def(8'hbc, O_LDY, M_ABX); def(8'hbd, O_LDA, M_ABX); def(8'hbe, O_LDX, M_ABY);
      def(8'hc0, O_CPY, M_IMM); def(8'hc1, O_CMP, M_IDX); def(8'hc2, O_NOP, M_IMM);
      def(8'hc4, O_CPY, M_ZPG); def(8'hc5, O_CMP, M_ZPG); def(8'hc6, O_DEC, M_ZPG);
      def(8'hc8, O_INY, M_IMP); def(8'hc9, O_CMP, M_IMM); def(8'hca, O_DEX, M_IMP);
      def(8'hcc, O_CPY, M_ABS); def(8'hcd, O_CMP, M_ABS); def(8'hce, O_DEC, M_ABS);
      def(8'hd0, O_BNE, M_REL); def(8'hd1, O_CMP, M_IDY); def(8'hd4, O_NOP, M_ZPX);
      def(8'hd5, O_CMP, M_ZPX); def(8'hd6, O_DEC, M_ZPX); def(8'hd8, O_CLD, M_IMP);
      def(8'hd9, O_CMP, M_ABY); def(8'hda, O_NOP, M_IMP); def(8'hdc, O_NOP, M_ABX);
      def(8'hdd, O_CMP, M_ABX); def(8'hde, O_DEC, M_ABX); def(8'he0, O_CPX, M_IMM);
      def(8'he1, O_SBC, M_IDX); def(8'he2, O_NOP, M_IMM); def(8'he4, O_CPX, M_ZPG);
      def(8'he5, O_SBC, M_ZPG); def(8'he6, O_INC, M_ZPG); def(8'he8, O_INX, M_IMP);
      def(8'he9, O_SBC, M_IMM); def(8'hea, O_NOP, M_IMP); def(8'hec, O_CPX, M_ABS);
      def(8'hed, O_SBC, M_ABS); def(8'hee, O_INC, M_ABS); def(8'hf0, O_BEQ, M_REL);
      def(8'hf1, O_SBC, M_IDY); def(8'hf4, O_NOP, M_ZPX); def(8'hf5, O_SBC, M_ZPX);
      def(8'hf6, O_INC, M_ZPX); def(8'hf8, O_SED, M_IMP); def(8'hf9, O_SBC, M_ABY);
      def(8'hfa, O_NOP, M_IMP); def(8'hfc, O_NOP, M_ABX); def(8'hfd, O_SBC, M_ABX);
      def(8'hfe, O_INC, M_ABX);
   end

   // ---------------- processor model ----------------
   function automatic void bus_read(input logic [15:0] adr, input logic [3:0] nxt);
      m_bus.addr = adr; m_bus.wr = 1'b0; m_bus.data = 8'h00; m_step = nxt;
   endfunction

   function automatic void bus_store(input logic [15:0] adr, input logic [7:0] v,
                                     input logic [3:0] nxt);
      m_bus.addr = adr; m_bus.wr = 1'b1; m_bus.data = v; m_step = nxt;
   endfunction

   function automatic void stack_push(input logic [7:0] v, input logic [3:0] nxt);
      bus_store({cfg_stack_pg, m_sp}, v, nxt);
      m_sp = m_sp - 8'd1;
   endfunction

   function automatic void stack_pull(input logic [3:0] nxt);
      m_sp = m_sp + 8'd1;
      bus_read({cfg_stack_pg, m_sp}, nxt);
   endfunction

   function automatic logic [15:0] next_pc();
      logic [15:0] t;
      t = m_pc;
      m_pc = m_pc + 16'd1;
      return t;
   endfunction

   function automatic logic [7:0] set_nz(input logic [7:0] v);
      m_p[FL_Z] = (v == 8'h00);
      m_p[FL_N] = v[7];
      return v;
   endfunction

   function automatic void add_carry(input logic [7:0] m);
      logic [8:0] s;
      s = {1'b0, m_a} + {1'b0, m} + {8'h00, m_p[FL_C]};
      m_p[FL_V] = ~(m_a[7] ^ m[7]) & (m_a[7] ^ s[7]);
      m_p[FL_C] = s[8];
      m_a = set_nz(s[7:0]);
   endfunction

   function automatic void compare_to(input logic [7:0] r, input logic [7:0] m);
      m_p[FL_C] = (r >= m);
      void'(set_nz(r - m));
   endfunction

   function automatic logic [7:0] shift_step(input logic [5:0] op, input logic [7:0] v);
      logic c;
      c = m_p[FL_C];
      case (op)
         O_ASL: begin m_p[FL_C] = v[7]; v = {v[6:0], 1'b0}; end
         O_LSR: begin m_p[FL_C] = v[0]; v = {1'b0, v[7:1]}; end
         O_ROL: begin m_p[FL_C] = v[7]; v = {v[6:0], c}; end
         O_ROR: begin m_p[FL_C] = v[0]; v = {c, v[7:1]}; end
         O_INC: v = v + 8'd1;
         default: v = v - 8'd1;
      endcase
      return set_nz(v);
   endfunction

   function automatic void start_vector(input logic [15:0] vec);
      m_opc = 8'h00;
      m_pt = vec;
      stack_push(m_pc[15:8], ST_PUSH_HI);
   endfunction

   // interrupt poll at an instruction boundary, else fetch the next opcode
   function automatic void at_boundary(input logic irq);
      m_nmi_pend = m_nmi_lat;
      m_irq_pend = irq && !m_p[FL_I];
      if (m_nmi_pend) begin
         m_nmi_lat = 1'b0;
         start_vector(cfg_nmi_vec);
      end else if (m_irq_pend) begin
         start_vector(cfg_irq_vec);
      end else begin
         m_bus.fetch = 1'b1;
         bus_read(next_pc(), ST_OPCODE);
      end
   endfunction

   function automatic void run_implied(input logic [5:0] op, input logic irq);
      case (op)
         O_CLC: m_p[FL_C] = 1'b0;
         O_SEC: m_p[FL_C] = 1'b1;
         O_CLI: m_p[FL_I] = 1'b0;
         O_SEI: m_p[FL_I] = 1'b1;
         O_CLV: m_p[FL_V] = 1'b0;
         O_CLD: m_p[FL_D] = 1'b0;
         O_SED: m_p[FL_D] = 1'b1;
         O_TAX: m_x = set_nz(m_a);
         O_TAY: m_y = set_nz(m_a);
         O_TXA: m_a = set_nz(m_x);
         O_TYA: m_a = set_nz(m_y);
         O_TSX: m_x = set_nz(m_sp);
         O_TXS: m_sp = m_x;
         O_INX: m_x = set_nz(m_x + 8'd1);
         O_INY: m_y = set_nz(m_y + 8'd1);
         O_DEX: m_x = set_nz(m_x - 8'd1);
         O_DEY: m_y = set_nz(m_y - 8'd1);
         O_ASL, O_LSR, O_ROL, O_ROR: m_a = shift_step(op, m_a);
         default: ;
      endcase
      case (op)
         O_PHA: stack_push(m_a, ST_WDONE);
         O_PHP: stack_push(m_p | 8'h30, ST_WDONE);
         O_PLA, O_PLP, O_RTS, O_RTI: stack_pull(ST_PULL_A);
         O_BRK: begin
            void'(next_pc());
            start_vector(cfg_irq_vec);
         end
         default: at_boundary(irq);
      endcase
   endfunction

   function automatic void run_operand(input logic [5:0] op, input logic irq);
      case (op)
         O_NOP: at_boundary(irq);
         O_STA: bus_store(m_ea, m_a, ST_WDONE);
         O_STX: bus_store(m_ea, m_x, ST_WDONE);
         O_STY: bus_store(m_ea, m_y, ST_WDONE);
         O_ASL, O_LSR, O_ROL, O_ROR, O_INC, O_DEC: bus_read(m_ea, ST_RMW);
         O_JMP: begin
            m_pc = m_ea;
            at_boundary(irq);
         end
         O_JSR: begin
            m_pc = m_pc - 16'd1;
            stack_push(m_pc[15:8], ST_PUSH_HI);
         end
         default: bus_read(m_ea, ST_READ);
      endcase
   endfunction

   function automatic void load_op(input logic [5:0] op, input logic [7:0] m);
      case (op)
         O_ORA: m_a = set_nz(m_a | m);
         O_AND: m_a = set_nz(m_a & m);
         O_EOR: m_a = set_nz(m_a ^ m);
         O_ADC: add_carry(m);
         O_SBC: add_carry(~m);
         O_CMP: compare_to(m_a, m);
         O_CPX: compare_to(m_x, m);
         O_CPY: compare_to(m_y, m);
         O_BIT: begin
            m_p[FL_Z] = ((m & m_a) == 8'h00);
            m_p[FL_V] = m[6];
            m_p[FL_N] = m[7];
         end
         O_LDX: m_x = set_nz(m);
         O_LDY: m_y = set_nz(m);
         default: m_a = set_nz(m);
      endcase
   endfunction

   function automatic logic branch_taken(input logic [5:0] op);
      case (op)
         O_BPL: return !m_p[FL_N];
         O_BMI: return m_p[FL_N];
         O_BVC: return !m_p[FL_V];
         O_BVS: return m_p[FL_V];
         O_BCC: return !m_p[FL_C];
         O_BCS: return m_p[FL_C];
         O_BNE: return !m_p[FL_Z];
         default: return m_p[FL_Z];
      endcase
   endfunction

   // one bus response in, next bus access out
   function automatic cpu65_bus_type next_bus_access(input logic [7:0] d, input logic irq,
                                                     input logic nmi);
      logic [5:0]  op;
      logic [3:0]  md;
      logic [15:0] base;
      op = decode_rom[m_opc][9:4];
      md = decode_rom[m_opc][3:0];
      if (nmi) m_nmi_lat = 1'b1;
      m_bus.fetch = 1'b0;
      if (m_halt) begin
         bus_read(HALT_ADDR, m_step);
      end else begin
         case (m_step)
            ST_RESET: begin
               m_pt = cfg_reset_vec;
               bus_read(m_pt, ST_VEC_LO);
            end
            ST_VEC_LO: begin
               m_ea = {8'h00, d};
               bus_read(m_pt + 16'd1, ST_VEC_HI);
            end
            ST_VEC_HI: begin
               m_pc = {d, m_ea[7:0]};
               m_p[FL_I] = 1'b1;
               at_boundary(irq);
            end
            ST_OPCODE: begin
               m_opc = d;
               op = decode_rom[d][9:4];
               md = decode_rom[d][3:0];
               if (op == O_BAD) begin
                  m_halt = 1'b1;
                  bus_read(HALT_ADDR, ST_OPCODE);
               end else if (md == M_IMP || md == M_ACC) begin
                  run_implied(op, irq);
               end else if (md == M_IMM) begin
                  m_ea = next_pc();
                  run_operand(op, irq);
               end else begin
                  bus_read(next_pc(), ST_OPER1);
               end
            end
            ST_OPER1: begin
               case (md)
                  M_ZPG: begin m_ea = {8'h00, d}; run_operand(op, irq); end
                  M_ZPX: begin m_ea = {8'h00, d + m_x}; run_operand(op, irq); end
                  M_ZPY: begin m_ea = {8'h00, d + m_y}; run_operand(op, irq); end
                  M_REL: begin
                     if (branch_taken(op)) m_pc = m_pc + {{8{d[7]}}, d};
                     at_boundary(irq);
                  end
                  M_IDX: begin m_pt = {8'h00, d + m_x}; bus_read(m_pt, ST_PTR_LO); end
                  M_IDY: begin m_pt = {8'h00, d}; bus_read(m_pt, ST_PTR_LO); end
                  default: begin m_ea = {8'h00, d}; bus_read(next_pc(), ST_ABS_HI); end
               endcase
            end
            ST_ABS_HI: begin
               base = {d, m_ea[7:0]};
               if (md == M_IND) begin
                  m_pt = base;
                  bus_read(base, ST_PTR_LO);
               end else begin
                  if (md == M_ABX) base = base + {8'h00, m_x};
                  else if (md == M_ABY) base = base + {8'h00, m_y};
                  m_ea = base;
                  run_operand(op, irq);
               end
            end
            ST_PTR_LO: begin
               m_ea = {8'h00, d};
               // pointer high byte stays in its page
               if (md == M_IND) bus_read({m_pt[15:8], m_pt[7:0] + 8'd1}, ST_PTR_HI);
               else bus_read({8'h00, m_pt[7:0] + 8'd1}, ST_PTR_HI);
            end
            ST_PTR_HI: begin
               base = {d, m_ea[7:0]};
               if (md == M_IND) begin
                  m_pc = base;
                  at_boundary(irq);
               end else begin
                  if (md == M_IDY) base = base + {8'h00, m_y};
                  m_ea = base;
                  run_operand(op, irq);
               end
            end
            ST_READ: begin
               load_op(op, d);
               at_boundary(irq);
            end
            ST_RMW: bus_store(m_ea, shift_step(op, d), ST_WDONE);
            ST_WDONE: at_boundary(irq);
            ST_PUSH_HI: stack_push(m_pc[7:0], ST_PUSH_LO);
            ST_PUSH_LO: begin
               if (op == O_JSR) begin
                  m_pc = m_ea;
                  at_boundary(irq);
               end else begin
                  stack_push(m_p | ((m_nmi_pend || m_irq_pend) ? 8'h20 : 8'h30), ST_PUSH_P);
               end
            end
            ST_PUSH_P: begin
               m_p[FL_I] = 1'b1;
               bus_read(m_pt, ST_VEC_LO);
            end
            ST_PULL_A: begin
               if (op == O_PLA) begin
                  m_a = set_nz(d);
                  at_boundary(irq);
               end else if (op == O_PLP) begin
                  m_p = d & P_KEEP;
                  at_boundary(irq);
               end else if (op == O_RTS) begin
                  m_ea = {8'h00, d};
                  m_pt = 16'd1;
                  stack_pull(ST_PULL_B);
               end else begin
                  m_p = d & P_KEEP;
                  m_pt = 16'd0;
                  stack_pull(ST_PULL_B);
               end
            end
            default: begin
               // return address bytes, after the flags for a return from interrupt
               if (m_pt == 16'd0) begin
                  m_ea = {8'h00, d};
                  m_pt = 16'd1;
                  stack_pull(ST_PULL_B);
               end else begin
                  base = {d, m_ea[7:0]};
                  if (op == O_RTS) base = base + 16'd1;
                  m_pc = base;
                  at_boundary(irq);
               end
            end
         endcase
      end
      m_bus.halt = m_halt;
      return m_bus;
   endfunction

   // ---------------- stimulus helpers ----------------
   task automatic write_csr(input logic [7:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RESET_VEC: cfg_reset_vec = val;
         CSR_IRQ_VEC:   cfg_irq_vec = val;
         CSR_NMI_VEC:   cfg_nmi_vec = val;
         default:       cfg_stack_pg = val[7:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // offer one item; typed expectation overrides the model's output
   task automatic send_item(input logic [7:0] d, input logic irq, input logic nmi,
                            input bit typed, input cpu65_bus_type typed_bus);
      cpu65_bus_type predicted;
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_read_data <= d;
      req_irq_level <= irq;
      req_nmi_fell <= nmi;
      do @(posedge clock); while (req_stall);
      predicted = next_bus_access(d, irq, nmi);
      bus_expected.push_back(typed ? typed_bus : predicted);
   endtask

   // response byte shaped by what the core just asked for
   task automatic send_random(input bit allow_halt);
      logic [7:0] d;
      logic irq, nmi;
      d = 8'($urandom_range(255));
      if (m_bus.fetch && !allow_halt)
         while (decode_rom[d][9:4] == O_BAD) d = 8'($urandom_range(255));
      irq = ($urandom_range(99) < 10);
      nmi = ($urandom_range(99) < 2);
      send_item(d, irq, nmi, 1'b0, '0);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (bus_expected.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // ---------------- directed program ----------------
   typedef struct {
      logic [7:0]    d;
      logic          irq;
      logic          nmi;
      bit            typed;
      cpu65_bus_type bus;
   } stim_row_type;

   stim_row_type program_rows [] = '{
      '{8'h5a, 1'b0, 1'b0, 1'b1, '{16'hffff, 1'b0, 8'h00, 1'b0, 1'b0}}, // reset vector
      '{8'h00, 1'b0, 1'b0, 1'b1, '{16'h0000, 1'b0, 8'h00, 1'b0, 1'b0}}, // vector wraps
      '{8'h80, 1'b0, 1'b0, 1'b1, '{16'h8000, 1'b0, 8'h00, 1'b1, 1'b0}},
      '{8'ha9, 1'b0, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, 1'b0, '0},  // lda #ff
      '{8'h69, 1'b0, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, 1'b0, '0},  // adc carry out
      '{8'he9, 1'b0, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, 1'b0, '0},  // sbc overflow
      '{8'h6c, 1'b0, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, 1'b0, '0},  // jmp (10ff)
      '{8'h10, 1'b0, 1'b0, 1'b0, '0},
      '{8'h34, 1'b0, 1'b0, 1'b1, '{16'h1000, 1'b0, 8'h00, 1'b0, 1'b0}}, // page wrap
      '{8'h12, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b1, '{16'hfffd, 1'b1, 8'h12, 1'b0, 1'b0}}, // brk
      '{8'hff, 1'b1, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h90, 1'b0, 1'b0, 1'b0, '0},
      '{8'h58, 1'b1, 1'b0, 1'b0, '0},                                   // cli with irq
      '{8'h00, 1'b1, 1'b1, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      '{8'h90, 1'b0, 1'b0, 1'b0, '0}                                    // nmi next
   };

   // ---------------- sender ----------------
   initial begin
      cfg_reset_vec = 16'hfffc; cfg_irq_vec = 16'hfffe;
      cfg_nmi_vec = 16'hfffa;   cfg_stack_pg = 8'h01;
      m_pc = '0; m_ea = '0; m_pt = '0; m_a = '0; m_x = '0; m_y = '0;
      m_sp = 8'hfd; m_p = 8'h04; m_opc = '0; m_step = ST_RESET;
      m_nmi_lat = 0; m_nmi_pend = 0; m_irq_pend = 0; m_halt = 0; m_bus = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase one: extremes of every register
      write_csr(CSR_RESET_VEC, 16'hffff);
      write_csr(CSR_IRQ_VEC, 16'h0000);
      write_csr(CSR_NMI_VEC, 16'hffff);
      write_csr(CSR_STACK_PG, 16'h00ff);
      foreach (program_rows[i])
         send_item(program_rows[i].d, program_rows[i].irq, program_rows[i].nmi,
                   program_rows[i].typed, program_rows[i].bus);
      for (int i = 0; i < 250; i++) begin
         if (i == 60) hold_off = 1'b1;
         // let the core run dry once
         if (i == 150) drain();
         send_random(1'b0);
      end
      drain();

      // phase two: sender slow, receiver fast
      write_csr(CSR_RESET_VEC, 16'h1234);
      write_csr(CSR_IRQ_VEC, 16'hfffe);
      write_csr(CSR_NMI_VEC, 16'hfffa);
      write_csr(CSR_STACK_PG, 16'h0000);
      send_idle_pct = 83;
      recv_idle_pct = 7;
      for (int i = 0; i < 230; i++) send_random(1'b0);
      drain();

      // phase three: no idling, ends on an undefined opcode
      write_csr(CSR_IRQ_VEC, 16'h8000);
      write_csr(CSR_NMI_VEC, 16'h0000);
      write_csr(CSR_STACK_PG, 16'h0001);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 240; i++) send_random(1'b0);
      while (!m_bus.fetch) send_random(1'b0);
      send_item(8'h02, 1'b0, 1'b0, 1'b1, '{HALT_ADDR, 1'b0, 8'h00, 1'b0, 1'b1});
      for (int i = 0; i < 5; i++) send_random(1'b1);
      @(negedge clock);
      req_valid <= 1'b0;
      while (bus_expected.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // ---------------- receiver ----------------
   initial begin
      int held;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            // long hold-off so the core backs up into its input
            rsp_stall <= 1'b1;
            held++;
            if (held == 60) hold_off = 1'b0;
         end else begin
            rsp_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      cpu65_bus_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bus_expected.size() == 0) begin
            $display("%0t: unexpected bus access %h", $time, rsp_bus_address);
            errors++;
         end else begin
            want = bus_expected.pop_front();
            if (rsp_bus_address !== want.addr) begin
               $display("%0t: address exp %h got %h", $time, want.addr, rsp_bus_address);
               errors++;
            end
            if (rsp_bus_write !== want.wr) begin
               $display("%0t: write exp %b got %b", $time, want.wr, rsp_bus_write);
               errors++;
            end
            if (rsp_write_data !== want.data) begin
               $display("%0t: wdata exp %h got %h", $time, want.data, rsp_write_data);
               errors++;
            end
            if (rsp_opcode_fetch !== want.fetch) begin
               $display("%0t: fetch exp %b got %b", $time, want.fetch, rsp_opcode_fetch);
               errors++;
            end
            if (rsp_halted !== want.halt) begin
               $display("%0t: halted exp %b got %b", $time, want.halt, rsp_halted);
               errors++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
